[design/lkvc_pkg.sv]
// Package for the LRU key/value cache.
// Default sizes, configuration register layout and operation codes.
// No dependencies.
package lkvc_pkg;

  localparam int SLOTS_DEF      = 16;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  localparam int               CFG_W     = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_FIND   = 1'b1;

endpackage

[design/lkvc_if.sv]
// Request and response channel interfaces of the LRU key/value cache.
// Valid/ready handshake; a transaction completes when both are high.
// No dependencies.
interface lkvc_req_if #(
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, kind, key, value, input ready);
  modport sink   (input valid, kind, key, value, output ready);
endinterface

interface lkvc_rsp_if #(
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [VALUE_BITS-1:0] value_out;
  logic                  evicted;
  logic [KEY_BITS-1:0]   evicted_key;

  modport source (output valid, hit, value_out, evicted, evicted_key, input ready);
  modport sink   (input valid, hit, value_out, evicted, evicted_key, output ready);
endinterface

[design/lkvc_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read port.
// Used for the tag/age store and the value store. No dependencies.
module lkvc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[design/lkvc_engine.sv]
// Lookup and replacement sequencer of the LRU key/value cache.
// Scans the tag/age RAM, then rewrites ages in a second pass; holds valid bits.
// Depends on lkvc_pkg, lkvc_if and lkvc_ram.
module lkvc_engine #(
  parameter int SLOTS      = lkvc_pkg::SLOTS_DEF,
  parameter int KEY_BITS   = lkvc_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lkvc_pkg::VALUE_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [$clog2(SLOTS+1)-1:0] limit_i,
  lkvc_req_if.sink                   req_i,
  lkvc_rsp_if.source                 rsp_o
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int AGE_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS+1);
  localparam int TAG_W = KEY_BITS + AGE_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_UPDATE = 3'd3;
  localparam logic [2:0] ST_RESP   = 3'd4;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  logic [2:0]       state_q, state_d;
  logic [IDX_W-1:0] cnt_q;
  logic [SLOTS-1:0] valid_q;
  logic [CNT_W-1:0] occ_q;

  logic                  kind_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;

  logic             found_q, free_q, old_any_q;
  logic [IDX_W-1:0] found_idx_q, free_idx_q, old_idx_q, tgt_q;
  logic [AGE_W-1:0] found_age_q, old_age_q;
  logic [KEY_BITS-1:0] old_key_q;
  logic [CNT_W-1:0] thresh_q;

  logic                  res_hit_q, res_ev_q;
  logic [VALUE_BITS-1:0] res_val_q;
  logic [KEY_BITS-1:0]   res_evkey_q;

  logic                  out_valid_q, out_hit_q, out_ev_q;
  logic [VALUE_BITS-1:0] out_val_q;
  logic [KEY_BITS-1:0]   out_evkey_q;

  // memory ports
  logic [IDX_W-1:0]      tag_raddr, tag_waddr, val_raddr, val_waddr;
  logic [TAG_W-1:0]      tag_rdata, tag_wdata;
  logic                  tag_we, val_re, val_we;
  logic [VALUE_BITS-1:0] val_rdata;

  logic [KEY_BITS-1:0] rkey;
  logic [AGE_W-1:0]    rage;
  logic                rvalid;

  // decision
  logic             dec_upd, dec_new, dec_hit, dec_ev;
  logic [IDX_W-1:0] dec_tgt;
  logic [CNT_W-1:0] dec_thresh;

  logic accept, load_out, scan_last;

  lkvc_ram #(.WIDTH(TAG_W), .DEPTH(SLOTS)) u_tag_ram (
    .clk_i   (clk_i),
    .re_i    (1'b1),
    .raddr_i (tag_raddr),
    .rdata_o (tag_rdata),
    .we_i    (tag_we),
    .waddr_i (tag_waddr),
    .wdata_i (tag_wdata)
  );

  lkvc_ram #(.WIDTH(VALUE_BITS), .DEPTH(SLOTS)) u_val_ram (
    .clk_i   (clk_i),
    .re_i    (val_re),
    .raddr_i (val_raddr),
    .rdata_o (val_rdata),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (value_q)
  );

  assign rkey   = tag_rdata[TAG_W-1:AGE_W];
  assign rage   = tag_rdata[AGE_W-1:0];
  assign rvalid = valid_q[cnt_q];

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign load_out    = (state_q == ST_RESP) && (!out_valid_q || rsp_o.ready);
  assign scan_last   = (cnt_q == LAST_IDX);

  assign tag_raddr = (state_q == ST_SCAN || state_q == ST_UPDATE) ?
                     cnt_q + IDX_W'(1) : '0;
  assign tag_we    = (state_q == ST_UPDATE);
  assign tag_waddr = cnt_q;

  always_comb begin
    if (cnt_q == tgt_q) begin
      tag_wdata = {key_q, AGE_W'(0)};
    end else if (rvalid && (CNT_W'(rage) < thresh_q)) begin
      tag_wdata = {rkey, rage + AGE_W'(1)};
    end else begin
      tag_wdata = tag_rdata;
    end
  end

  always_comb begin
    dec_upd    = 1'b0;
    dec_new    = 1'b0;
    dec_hit    = 1'b0;
    dec_ev     = 1'b0;
    dec_tgt    = found_idx_q;
    dec_thresh = CNT_W'(found_age_q);
    if (found_q) begin
      dec_upd = 1'b1;
      dec_hit = 1'b1;
    end else if (kind_q == lkvc_pkg::KIND_INSERT) begin
      if (occ_q < limit_i) begin
        dec_upd    = 1'b1;
        dec_new    = 1'b1;
        dec_tgt    = free_idx_q;
        dec_thresh = occ_q;
      end else if (old_any_q) begin
        dec_upd    = 1'b1;
        dec_ev     = 1'b1;
        dec_tgt    = old_idx_q;
        dec_thresh = CNT_W'(old_age_q);
      end
    end
  end

  assign val_re    = (state_q == ST_DECIDE) && (kind_q == lkvc_pkg::KIND_FIND);
  assign val_raddr = found_idx_q;
  assign val_we    = (state_q == ST_DECIDE) && (kind_q == lkvc_pkg::KIND_INSERT) && dec_upd;
  assign val_waddr = dec_tgt;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_d = dec_upd ? ST_UPDATE : ST_RESP;
      end
      ST_UPDATE: begin
        if (scan_last) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      valid_q     <= '0;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_SCAN || state_q == ST_UPDATE) begin
        cnt_q <= cnt_q + IDX_W'(1);
      end else begin
        cnt_q <= '0;
      end
      if (state_q == ST_DECIDE && dec_new) begin
        valid_q[dec_tgt] <= 1'b1;
        occ_q            <= occ_q + CNT_W'(1);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q    <= req_i.kind;
      key_q     <= req_i.key;
      value_q   <= req_i.value;
      found_q   <= 1'b0;
      free_q    <= 1'b0;
      old_any_q <= 1'b0;
    end
    if (state_q == ST_SCAN) begin
      if (rvalid && (rkey == key_q) && !found_q) begin
        found_q     <= 1'b1;
        found_idx_q <= cnt_q;
        found_age_q <= rage;
      end
      if (!rvalid && !free_q) begin
        free_q     <= 1'b1;
        free_idx_q <= cnt_q;
      end
      if (rvalid && (!old_any_q || rage > old_age_q)) begin
        old_any_q <= 1'b1;
        old_idx_q <= cnt_q;
        old_age_q <= rage;
        old_key_q <= rkey;
      end
    end
    if (state_q == ST_DECIDE) begin
      tgt_q       <= dec_tgt;
      thresh_q    <= dec_thresh;
      res_hit_q   <= dec_hit;
      res_ev_q    <= dec_ev;
      res_evkey_q <= dec_ev ? old_key_q : '0;
      res_val_q   <= '0;
    end
    if (state_q == ST_UPDATE && cnt_q == '0 && kind_q == lkvc_pkg::KIND_FIND) begin
      res_val_q <= val_rdata;
    end
    if (load_out) begin
      out_hit_q   <= res_hit_q;
      out_val_q   <= res_val_q;
      out_ev_q    <= res_ev_q;
      out_evkey_q <= res_evkey_q;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.hit         = out_hit_q;
  assign rsp_o.value_out   = out_val_q;
  assign rsp_o.evicted     = out_ev_q;
  assign rsp_o.evicted_key = out_evkey_q;

endmodule

[design/lru_key_value_cache_top.sv]
// Top level of the LRU key/value cache.
// Holds the slot limit register and instantiates the sequencer.
// Depends on lkvc_pkg, lkvc_if and lkvc_engine.
//
// Usage:
//   req_i carries one operation per transaction: kind (insert or find), key, value.
//   rsp_o returns one result per operation: hit, value_out, evicted, evicted_key.
//   cfg_we_i/cfg_wdata_i write the active slot limit (0 acts as 1, above SLOTS
//   as SLOTS); write it only while no operation is in flight.
// Sequence:
//   An operation scans the tag/age RAM one slot per cycle, passes through a
//   decision state, then, unless it is a find miss, rewrites the ages one
//   slot per cycle, then loads the output register and returns to idle to
//   accept the next request.
//   One operation is processed at a time; the next one is taken while the last
//   result still waits in the output register.
// Reset clears all entries (valid bits and occupancy) and sets the limit to 16.
// If rsp_o stalls, the result holds and a finished operation waits to load it.
module lru_key_value_cache_top #(
  parameter int SLOTS      = lkvc_pkg::SLOTS_DEF,
  parameter int KEY_BITS   = lkvc_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lkvc_pkg::VALUE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lkvc_pkg::CFG_W-1:0]  cfg_wdata_i,
  lkvc_req_if.sink                    req_i,
  lkvc_rsp_if.source                  rsp_o
);

  localparam int CNT_W = $clog2(SLOTS+1);
  localparam int LIM_W = (CNT_W > lkvc_pkg::CFG_W) ? CNT_W : lkvc_pkg::CFG_W;

  logic [lkvc_pkg::CFG_W-1:0] active_q;
  logic [LIM_W-1:0]           active_ext, slots_ext, limit_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= lkvc_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      active_q <= cfg_wdata_i;
    end
  end

  assign active_ext = LIM_W'(active_q);
  assign slots_ext  = LIM_W'(SLOTS);

  always_comb begin
    if (active_q == '0) begin
      limit_ext = LIM_W'(1);
    end else if (active_ext > slots_ext) begin
      limit_ext = slots_ext;
    end else begin
      limit_ext = active_ext;
    end
  end

  lkvc_engine #(
    .SLOTS      (SLOTS),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_engine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .limit_i (limit_ext[CNT_W-1:0]),
    .req_i   (req_i),
    .rsp_o   (rsp_o)
  );

endmodule

[dv/lru_key_value_cache_top_tb.sv]
// Self-checking testbench for the LRU key/value cache top level.
// Predicts hit, value and eviction per transaction and compares them in order.
// Depends on lkvc_pkg, lkvc_if and lru_key_value_cache_top.
`timescale 1ns / 100ps

module lru_key_value_cache_top_tb;

  localparam int SLOTS       = lkvc_pkg::SLOTS_DEF;
  localparam int KEY_W       = lkvc_pkg::KEY_BITS_DEF;
  localparam int VAL_W       = lkvc_pkg::VALUE_BITS_DEF;
  localparam int CFG_W       = lkvc_pkg::CFG_W;
  localparam int OP_LATENCY  = 2 * SLOTS + 3;
  localparam int END_SLACK   = 4 * OP_LATENCY;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int POOL_SIZE   = 20;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] value_out;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
  } lookup_result_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  lkvc_req_if #(.KEY_BITS(KEY_W), .VALUE_BITS(VAL_W)) req_if ();
  lkvc_rsp_if #(.KEY_BITS(KEY_W), .VALUE_BITS(VAL_W)) rsp_if ();

  lru_key_value_cache_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  // cache shadow state
  logic [KEY_W-1:0] lru_keys   [SLOTS];
  logic [VAL_W-1:0] lru_values [SLOTS];
  bit               lru_valid  [SLOTS];
  int               lru_age    [SLOTS];
  int               lru_count;
  logic [CFG_W-1:0] lru_limit;

  lookup_result_t   pending_results[$];
  logic [KEY_W-1:0] key_pool[POOL_SIZE];
  bit               req_gaps_on;
  bit               rsp_stalls_on;
  int               stall_left;
  int               fail_count;
  int               cycle_count;
  int               result_count;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic report_failure(string msg);
    if (fail_count < 50) $display("ERROR cycle %0d: %s", cycle_count, msg);
    fail_count++;
  endtask

  function automatic void make_newest(int s);
    int old_age;
    old_age = lru_age[s];
    for (int i = 0; i < SLOTS; i++) begin
      if (i != s && lru_valid[i] && lru_age[i] < old_age) lru_age[i]++;
    end
    lru_age[s] = 0;
  endfunction

  function automatic lookup_result_t predict_lookup(logic kind, logic [KEY_W-1:0] key,
                                                    logic [VAL_W-1:0] data);
    lookup_result_t res;
    int hit_slot;
    int free_slot;
    int victim;
    int cap;
    res       = '0;
    hit_slot  = -1;
    free_slot = -1;
    victim    = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (hit_slot < 0 && lru_valid[i] && lru_keys[i] == key) hit_slot = i;
    end
    cap = (lru_limit == 0) ? 1 : ((lru_limit > SLOTS) ? SLOTS : int'(lru_limit));
    if (hit_slot >= 0) begin
      res.hit = 1'b1;
      if (kind == lkvc_pkg::KIND_FIND) res.value_out = lru_values[hit_slot];
      else lru_values[hit_slot] = data;
      make_newest(hit_slot);
    end else if (kind == lkvc_pkg::KIND_INSERT) begin
      if (lru_count < cap) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (free_slot < 0 && !lru_valid[i]) free_slot = i;
        end
        for (int i = 0; i < SLOTS; i++) begin
          if (lru_valid[i]) lru_age[i]++;
        end
        lru_valid[free_slot]  = 1'b1;
        lru_keys[free_slot]   = key;
        lru_values[free_slot] = data;
        lru_age[free_slot]    = 0;
        lru_count++;
      end else begin
        for (int i = 0; i < SLOTS; i++) begin
          if (lru_valid[i] && (victim < 0 || lru_age[i] > lru_age[victim])) victim = i;
        end
        res.evicted      = 1'b1;
        res.evicted_key  = lru_keys[victim];
        lru_keys[victim]   = key;
        lru_values[victim] = data;
        make_newest(victim);
      end
    end
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!req_gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(15, 60);
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    int               r;
    logic [KEY_W-1:0] k;
    r = $urandom_range(0, 99);
    if (r < 80) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    k = $urandom;
    if (r < 85) key_pool[$urandom_range(2, POOL_SIZE - 1)] = k;
    return k;
  endfunction

  // response side: random back-pressure and in-order compare
  task automatic check_result();
    lookup_result_t want;
    result_count++;
    if (pending_results.size() == 0) begin
      report_failure($sformatf("unexpected transaction, hit %b value %h", rsp_if.hit,
                               rsp_if.value_out));
    end else begin
      want = pending_results.pop_front();
      if (rsp_if.hit !== want.hit)
        report_failure($sformatf("result %0d hit %b, want %b", result_count,
                                 rsp_if.hit, want.hit));
      if (rsp_if.value_out !== want.value_out)
        report_failure($sformatf("result %0d value_out %h, want %h", result_count,
                                 rsp_if.value_out, want.value_out));
      if (rsp_if.evicted !== want.evicted)
        report_failure($sformatf("result %0d evicted %b, want %b", result_count,
                                 rsp_if.evicted, want.evicted));
      if (rsp_if.evicted_key !== want.evicted_key)
        report_failure($sformatf("result %0d evicted_key %h, want %h", result_count,
                                 rsp_if.evicted_key, want.evicted_key));
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) check_result();
      if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_if.ready <= 1'b1;
        if (rsp_stalls_on) begin
          case ($urandom_range(0, 99)) inside
            [0:17]:  stall_left = $urandom_range(1, 3);
            [18:20]: stall_left = $urandom_range(12, 60);
            default: stall_left = 0;
          endcase
        end
      end
    end
  end

  task automatic send_op(logic kind, logic [KEY_W-1:0] key, logic [VAL_W-1:0] data);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.kind  <= kind;
    req_if.key   <= key;
    req_if.value <= data;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    pending_results.push_back(predict_lookup(kind, key, data));
  endtask

  task automatic wait_all_results();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic set_limit(logic [CFG_W-1:0] limit);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= limit;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    lru_limit    = limit;
  endtask

  // limit of zero behaves as one, then a three-entry cache fills and evicts
  task automatic test_small_limit();
    set_limit(5'd0);
    send_op(lkvc_pkg::KIND_INSERT, 32'hA5A5_0001, 32'h1111_1111);
    send_op(lkvc_pkg::KIND_INSERT, 32'hA5A5_0002, 32'h2222_2222);
    send_op(lkvc_pkg::KIND_FIND,   32'hA5A5_0001, 32'h0);
    wait_all_results();
    set_limit(5'd3);
    send_op(lkvc_pkg::KIND_INSERT, 32'hA5A5_0003, 32'h3333_3333);
    send_op(lkvc_pkg::KIND_INSERT, 32'hA5A5_0004, 32'h4444_4444);
    send_op(lkvc_pkg::KIND_INSERT, 32'hA5A5_0005, 32'h5555_5555);
    send_op(lkvc_pkg::KIND_FIND,   32'hA5A5_0003, 32'h0);
  endtask

  // field extremes, insert hit, find miss, fill to full and evict
  task automatic test_extremes_and_fill();
    wait_all_results();
    set_limit(5'd31);
    send_op(lkvc_pkg::KIND_FIND,   32'h0000_0000, 32'h0);
    send_op(lkvc_pkg::KIND_INSERT, 32'h0000_0000, 32'h0000_0000);
    send_op(lkvc_pkg::KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(lkvc_pkg::KIND_FIND,   32'h0000_0000, 32'h0);
    send_op(lkvc_pkg::KIND_FIND,   32'hFFFF_FFFF, 32'h0);
    send_op(lkvc_pkg::KIND_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_op(lkvc_pkg::KIND_FIND,   32'h0000_0000, 32'hFFFF_FFFF);
    send_op(lkvc_pkg::KIND_FIND,   32'h8000_0000, 32'hFFFF_FFFF);
    for (int i = 0; i < 11; i++)
      send_op(lkvc_pkg::KIND_INSERT, 32'h0100_0000 + i * 32'h0101, $urandom);
    send_op(lkvc_pkg::KIND_INSERT, 32'h1234_5678, 32'h8765_4321);
    send_op(lkvc_pkg::KIND_FIND,   32'hA5A5_0003, 32'h0);
  endtask

  task automatic test_random_traffic(int n_ops, logic [CFG_W-1:0] limit, bit gaps, bit stalls);
    wait_all_results();
    set_limit(limit);
    req_gaps_on   = gaps;
    rsp_stalls_on = stalls;
    for (int i = 0; i < n_ops; i++)
      send_op($urandom_range(0, 1) ? lkvc_pkg::KIND_FIND : lkvc_pkg::KIND_INSERT,
              pick_key(), $urandom);
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    req_if.valid  = 1'b0;
    req_if.kind   = lkvc_pkg::KIND_INSERT;
    req_if.key    = '0;
    req_if.value  = '0;
    req_gaps_on   = 1'b1;
    rsp_stalls_on = 1'b1;
    lru_count     = 0;
    lru_limit     = lkvc_pkg::CFG_RESET;
    for (int i = 0; i < SLOTS; i++) begin
      lru_valid[i]  = 1'b0;
      lru_age[i]    = 0;
      lru_keys[i]   = '0;
      lru_values[i] = '0;
    end
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_small_limit();
    test_extremes_and_fill();
    test_random_traffic(250, 5'd16, 1'b1, 1'b1);
    test_random_traffic(250, 5'd1,  1'b1, 1'b1);
    test_random_traffic(250, 5'd8,  1'b0, 1'b0);
    test_random_traffic(250, 5'd31, 1'b1, 1'b1);
    test_random_traffic(250, 5'd0,  1'b1, 1'b0);
    test_random_traffic(250, 5'($urandom_range(2, 15)), 1'b0, 1'b1);

    wait_all_results();
    repeat (END_SLACK) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
